@@ design/block_extent_set_engine_unit_assert.svh @@
// Assertion macros for the extent set engine.
// Included by modules that check their own control sequencing.
`ifndef BLOCK_EXTENT_SET_ENGINE_UNIT_ASSERT_SVH
`define BLOCK_EXTENT_SET_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BES_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("extent set engine check failed");
`define BES_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("extent set engine check failed");
`else
`define BES_ASSERT_SAME(lbl, ante, cons)
`define BES_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/bes_pkg.sv @@
// Shared types and codes of the extent set engine.
// No dependencies.
package bes_pkg;

   localparam int DATA_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [2:0] OP_ADD        = 3'd0;
   localparam logic [2:0] OP_REMOVE     = 3'd1;
   localparam logic [2:0] OP_NEXT_RANGE = 3'd2;
   localparam logic [2:0] OP_NEXT_FREE  = 3'd3;
   localparam logic [2:0] OP_CHECK      = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_START = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_END   = 1'd1;

   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_INS  = 2'd1;
   localparam logic [1:0] SH_DEL  = 2'd2;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic eval;
      logic wr1;
      logic shift_init;
      logic shift_step;
      logic wr2;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic need_pass2;
      logic shift_done;
      logic out_free;
   } stat_type;

endpackage

@@ design/bes_ram.sv @@
// Generic one-write one-read RAM with registered read data.
// No dependencies.
module bes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ design/bes_ctrl.sv @@
// Sequencer of the extent set engine: scan, evaluate, write, shift, respond.
// Depends on bes_pkg and the assertion macro header.
`include "block_extent_set_engine_unit_assert.svh"
module bes_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bes_pkg::stat_type st,
   output bes_pkg::cmd_type  cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_WR1   = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_WR2   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_done) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = st.need_pass2 ? S_SCAN : S_WR1;
         end
         S_WR1: begin
            cmd.wr1        = 1'b1;
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (st.shift_done) state_in = S_WR2;
         end
         S_WR2: begin
            cmd.wr2  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BES_ASSERT_NEXT(a_accept_scans, req_valid && req_ready, state_ff == S_SCAN)
   `BES_ASSERT_NEXT(a_second_pass, state_ff == S_EVAL && st.need_pass2, state_ff == S_SCAN)
   `BES_ASSERT_NEXT(a_done_idle, state_ff == S_DONE && st.out_free, state_ff == S_IDLE)
endmodule

@@ design/bes_dp.sv @@
// Datapath of the extent set engine: extent tables, scan, decision, shift.
// Depends on bes_pkg and bes_ram.
module bes_dp #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bes_pkg::cmd_type               cmd,
   output bes_pkg::stat_type              st,
   input  logic [2:0]                     req_opcode,
   input  logic [bes_pkg::DATA_W-1:0]     req_first_block,
   input  logic [bes_pkg::DATA_W-1:0]     req_end_block,
   input  logic                           csr_valid,
   input  logic [bes_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bes_pkg::DATA_W-1:0]     csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [bes_pkg::DATA_W-1:0]     rsp_range_start,
   output logic [bes_pkg::DATA_W-1:0]     rsp_range_end,
   output logic [bes_pkg::DATA_W-1:0]     rsp_next_free,
   output logic                           rsp_all_in_set,
   output logic                           rsp_none_in_set
);
   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int DW = bes_pkg::DATA_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
   localparam logic [CW-1:0] ONE = CW'(1);

   // configuration
   logic [DW-1:0] init_start_ff, init_end_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_start_ff <= '0;
         init_end_ff   <= '0;
      end else if (csr_valid) begin
         if (csr_index == bes_pkg::CSR_INIT_START) init_start_ff <= csr_wdata;
         if (csr_index == bes_pkg::CSR_INIT_END)   init_end_ff   <= csr_wdata;
      end
   end

   // request
   logic [2:0]    op_ff;
   logic [DW-1:0] s_ff, e_ff, key_ff;
   logic          pass2_ff;
   logic [CW-1:0] count_ff;

   // memories
   logic          st_we, en_we;
   logic [AW-1:0] waddr, raddr;
   logic [DW-1:0] st_wdata, en_wdata, st_rdata, en_rdata;

   bes_ram #(.WIDTH(DW), .DEPTH(MAX_EXTENTS)) u_starts (
      .clock(clock), .we(st_we), .waddr(waddr), .wdata(st_wdata),
      .raddr(raddr), .rdata(st_rdata));
   bes_ram #(.WIDTH(DW), .DEPTH(MAX_EXTENTS)) u_ends (
      .clock(clock), .we(en_we), .waddr(waddr), .wdata(en_wdata),
      .raddr(raddr), .rdata(en_rdata));

   // scan and shift pointers
   logic [CW-1:0] rd_ptr_ff, pend_idx_ff, sh_rd_ff, sh_left_ff;
   logic          pend_ff;
   logic          fe_found_ff, fs_found_ff;
   logic [CW-1:0] fe_idx_ff, fs_idx_ff;
   logic [DW-1:0] fe_s_ff, fe_e_ff, fs_s_ff, fs_e_ff, prev_end_ff;

   // plan
   logic [1:0]    sh_mode_ff;
   logic [CW-1:0] sh_lo_ff;
   logic          w1_s_ff, w1_e_ff, w2_en_ff;
   logic [AW-1:0] w1_addr_ff, w2_addr_ff;
   logic [DW-1:0] w1_ds_ff, w1_de_ff, w2_ds_ff, w2_de_ff;
   logic          cnt_inc_ff, cnt_dec_ff;

   // result
   logic [1:0]    r_status_ff;
   logic [DW-1:0] r_start_ff, r_end_ff, r_free_ff;
   logic          r_all_ff, r_none_ff;
   logic          rsp_valid_ff;

   // evaluation of the scanned candidate
   logic          init_valid, hit_in, all_v, none_v, full, left, right, fits;
   logic [DW-1:0] cand_s, cand_e, nb_in, nb_out;
   logic [CW-1:0] i_add, i_add_m1, i_rem_p1;

   always_comb begin
      init_valid = init_start_ff < init_end_ff;
      if (fe_found_ff) begin
         cand_s = fe_s_ff;
         cand_e = fe_e_ff;
      end else if (init_valid && init_end_ff > key_ff) begin
         cand_s = init_start_ff;
         cand_e = init_end_ff;
      end else begin
         cand_s = '0;
         cand_e = '0;
      end
      hit_in   = (cand_s <= key_ff) && (key_ff < cand_e);
      nb_in    = hit_in ? key_ff : cand_s;
      nb_out   = hit_in ? cand_e : key_ff;
      all_v    = (nb_in == s_ff) && (nb_out >= e_ff);
      none_v   = (nb_in == '0) || (nb_in >= e_ff);
      full     = count_ff >= CNT_MAX;
      fits     = (s_ff < e_ff) && !init_valid;
      i_add    = fs_found_ff ? fs_idx_ff : count_ff;
      i_add_m1 = i_add - ONE;
      i_rem_p1 = fe_idx_ff + ONE;
      left     = (i_add != '0) && (prev_end_ff == s_ff);
      right    = fs_found_ff && (fs_s_ff == e_ff);
   end

   assign st.need_pass2 = (op_ff == bes_pkg::OP_NEXT_RANGE) && !pass2_ff && (nb_in != '0);
   assign st.scan_done  = !pend_ff && (rd_ptr_ff >= count_ff);
   assign st.shift_done = !pend_ff && (sh_left_ff == '0);
   assign st.out_free   = !rsp_valid_ff || rsp_ready;

   // memory ports
   logic [AW-1:0] sh_waddr;
   always_comb begin
      sh_waddr = (sh_mode_ff == bes_pkg::SH_INS) ? AW'(pend_idx_ff + ONE)
                                                 : AW'(pend_idx_ff - ONE);
      raddr    = cmd.shift_step ? sh_rd_ff[AW-1:0] : rd_ptr_ff[AW-1:0];
      st_we    = 1'b0;
      en_we    = 1'b0;
      waddr    = w1_addr_ff;
      st_wdata = w1_ds_ff;
      en_wdata = w1_de_ff;
      if (cmd.wr1) begin
         st_we = w1_s_ff;
         en_we = w1_e_ff;
      end else if (cmd.shift_step && pend_ff) begin
         st_we    = 1'b1;
         en_we    = 1'b1;
         waddr    = sh_waddr;
         st_wdata = st_rdata;
         en_wdata = en_rdata;
      end else if (cmd.wr2) begin
         st_we    = w2_en_ff;
         en_we    = w2_en_ff;
         waddr    = w2_addr_ff;
         st_wdata = w2_ds_ff;
         en_wdata = w2_de_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass2_ff     <= 1'b0;
      end else begin
         if (cmd.load) begin
            pend_ff  <= 1'b0;
            pass2_ff <= 1'b0;
         end else if (cmd.eval && st.need_pass2) begin
            pend_ff  <= 1'b0;
            pass2_ff <= 1'b1;
         end else if (cmd.scan_step) begin
            pend_ff <= rd_ptr_ff < count_ff;
         end else if (cmd.shift_init) begin
            pend_ff <= 1'b0;
         end else if (cmd.shift_step) begin
            pend_ff <= sh_left_ff != '0;
         end
         if (cmd.wr2) begin
            if (cnt_inc_ff) count_ff <= count_ff + ONE;
            else if (cnt_dec_ff) count_ff <= count_ff - ONE;
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // scan, shift and plan payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_opcode;
         s_ff        <= req_first_block;
         e_ff        <= req_end_block;
         key_ff      <= req_first_block;
         rd_ptr_ff   <= '0;
         fe_found_ff <= 1'b0;
         fs_found_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         if (rd_ptr_ff < count_ff) begin
            pend_idx_ff <= rd_ptr_ff;
            rd_ptr_ff   <= rd_ptr_ff + ONE;
         end
         if (pend_ff) begin
            if (!fe_found_ff && en_rdata > key_ff) begin
               fe_found_ff <= 1'b1;
               fe_idx_ff   <= pend_idx_ff;
               fe_s_ff     <= st_rdata;
               fe_e_ff     <= en_rdata;
            end
            if (!fs_found_ff) begin
               if (st_rdata > key_ff) begin
                  fs_found_ff <= 1'b1;
                  fs_idx_ff   <= pend_idx_ff;
                  fs_s_ff     <= st_rdata;
                  fs_e_ff     <= en_rdata;
               end else begin
                  prev_end_ff <= en_rdata;
               end
            end
         end
      end
      if (cmd.shift_init) begin
         case (sh_mode_ff)
            bes_pkg::SH_INS: begin
               sh_rd_ff   <= count_ff - ONE;
               sh_left_ff <= count_ff - sh_lo_ff;
            end
            bes_pkg::SH_DEL: begin
               sh_rd_ff   <= sh_lo_ff + ONE;
               sh_left_ff <= count_ff - ONE - sh_lo_ff;
            end
            default: begin
               sh_rd_ff   <= '0;
               sh_left_ff <= '0;
            end
         endcase
      end
      if (cmd.shift_step && sh_left_ff != '0) begin
         pend_idx_ff <= sh_rd_ff;
         sh_rd_ff    <= (sh_mode_ff == bes_pkg::SH_INS) ? sh_rd_ff - ONE : sh_rd_ff + ONE;
         sh_left_ff  <= sh_left_ff - ONE;
      end
      if (cmd.eval) begin
         // second pass of a range search restarts the scan at the found start
         if (st.need_pass2) begin
            key_ff      <= nb_in;
            rd_ptr_ff   <= '0;
            fe_found_ff <= 1'b0;
            fs_found_ff <= 1'b0;
         end
         sh_mode_ff  <= bes_pkg::SH_NONE;
         sh_lo_ff    <= '0;
         w1_s_ff     <= 1'b0;
         w1_e_ff     <= 1'b0;
         w2_en_ff    <= 1'b0;
         cnt_inc_ff  <= 1'b0;
         cnt_dec_ff  <= 1'b0;
         r_status_ff <= bes_pkg::ST_OK;
         r_free_ff   <= '0;
         r_all_ff    <= 1'b0;
         r_none_ff   <= 1'b0;
         if (!pass2_ff) begin
            r_start_ff <= '0;
            r_end_ff   <= '0;
         end
         case (op_ff)
            bes_pkg::OP_ADD: begin
               if (!fits || !none_v) begin
                  r_status_ff <= bes_pkg::ST_BAD;
               end else if (left && right) begin
                  w1_e_ff    <= 1'b1;
                  w1_addr_ff <= i_add_m1[AW-1:0];
                  w1_de_ff   <= fs_e_ff;
                  sh_mode_ff <= bes_pkg::SH_DEL;
                  sh_lo_ff   <= i_add;
                  cnt_dec_ff <= 1'b1;
               end else if (left) begin
                  w1_e_ff    <= 1'b1;
                  w1_addr_ff <= i_add_m1[AW-1:0];
                  w1_de_ff   <= e_ff;
               end else if (right) begin
                  w1_s_ff    <= 1'b1;
                  w1_addr_ff <= i_add[AW-1:0];
                  w1_ds_ff   <= s_ff;
               end else if (full) begin
                  r_status_ff <= bes_pkg::ST_FULL;
               end else begin
                  sh_mode_ff <= bes_pkg::SH_INS;
                  sh_lo_ff   <= i_add;
                  w2_en_ff   <= 1'b1;
                  w2_addr_ff <= i_add[AW-1:0];
                  w2_ds_ff   <= s_ff;
                  w2_de_ff   <= e_ff;
                  cnt_inc_ff <= 1'b1;
               end
            end
            bes_pkg::OP_REMOVE: begin
               if (!fits || !all_v || !fe_found_ff) begin
                  r_status_ff <= bes_pkg::ST_BAD;
               end else if (s_ff == fe_s_ff && e_ff == fe_e_ff) begin
                  sh_mode_ff <= bes_pkg::SH_DEL;
                  sh_lo_ff   <= fe_idx_ff;
                  cnt_dec_ff <= 1'b1;
               end else if (s_ff == fe_s_ff) begin
                  w1_s_ff    <= 1'b1;
                  w1_addr_ff <= fe_idx_ff[AW-1:0];
                  w1_ds_ff   <= e_ff;
               end else if (e_ff == fe_e_ff) begin
                  w1_e_ff    <= 1'b1;
                  w1_addr_ff <= fe_idx_ff[AW-1:0];
                  w1_de_ff   <= s_ff;
               end else if (full) begin
                  r_status_ff <= bes_pkg::ST_FULL;
               end else begin
                  // split: trim the left part, then open a slot for the right part
                  w1_e_ff    <= 1'b1;
                  w1_addr_ff <= fe_idx_ff[AW-1:0];
                  w1_de_ff   <= s_ff;
                  sh_mode_ff <= bes_pkg::SH_INS;
                  sh_lo_ff   <= i_rem_p1;
                  w2_en_ff   <= 1'b1;
                  w2_addr_ff <= i_rem_p1[AW-1:0];
                  w2_ds_ff   <= e_ff;
                  w2_de_ff   <= fe_e_ff;
                  cnt_inc_ff <= 1'b1;
               end
            end
            bes_pkg::OP_NEXT_RANGE: begin
               if (!pass2_ff) r_start_ff <= nb_in;
               else r_end_ff <= nb_out;
            end
            bes_pkg::OP_NEXT_FREE: r_free_ff <= nb_out;
            bes_pkg::OP_CHECK: begin
               r_all_ff  <= all_v;
               r_none_ff <= none_v;
            end
            default: r_status_ff <= bes_pkg::ST_BAD;
         endcase
      end
      if (cmd.finish) begin
         rsp_status      <= r_status_ff;
         rsp_range_start <= r_start_ff;
         rsp_range_end   <= r_end_ff;
         rsp_next_free   <= r_free_ff;
         rsp_all_in_set  <= r_all_ff;
         rsp_none_in_set <= r_none_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

@@ design/block_extent_set_engine_unit.sv @@
// Top level of the extent set engine: sequencer plus datapath.
// Depends on bes_pkg, bes_ctrl, bes_dp (and bes_ram through bes_dp).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   req     | req_valid/ready, opcode, first/end block | in
//   rsp     | rsp_valid/ready, status and result flags | out
//   csr     | csr_valid/ready, csr_index, csr_wdata    | in
//
// One request at a time; a next range search scans the table twice. Add and
// remove then write and shift the table through one RAM port pair. Reset
// empties the table at once.
// A stalled response holds in its register; the next request's response waits for it.
module block_extent_set_engine_unit #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_opcode,
   input  logic [bes_pkg::DATA_W-1:0]    req_first_block,
   input  logic [bes_pkg::DATA_W-1:0]    req_end_block,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [bes_pkg::DATA_W-1:0]    rsp_range_start,
   output logic [bes_pkg::DATA_W-1:0]    rsp_range_end,
   output logic [bes_pkg::DATA_W-1:0]    rsp_next_free,
   output logic                          rsp_all_in_set,
   output logic                          rsp_none_in_set,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bes_pkg::DATA_W-1:0]    csr_wdata
);
   bes_pkg::cmd_type  cmd;
   bes_pkg::stat_type st;

   assign csr_ready = 1'b1;

   bes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .st(st), .cmd(cmd));

   bes_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_opcode(req_opcode), .req_first_block(req_first_block),
      .req_end_block(req_end_block),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_range_start(rsp_range_start), .rsp_range_end(rsp_range_end),
      .rsp_next_free(rsp_next_free), .rsp_all_in_set(rsp_all_in_set),
      .rsp_none_in_set(rsp_none_in_set));
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for block_extent_set_engine_unit: directed and random
// requests against a cycle-free predictor of the sorted extent table.
// Depends on bes_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int TBL_DEPTH = 64;
   localparam int SETTLE_CYCLES = 2 * TBL_DEPTH + 40;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [31:0] next_free;
      logic        all_in_set;
      logic        none_in_set;
   } extent_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = '0;
   logic [31:0] req_first_block = '0;
   logic [31:0] req_end_block = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_range_start;
   logic [31:0] rsp_range_end;
   logic [31:0] rsp_next_free;
   logic        rsp_all_in_set;
   logic        rsp_none_in_set;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [bes_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor state
   logic [31:0] ext_lo [TBL_DEPTH];
   logic [31:0] ext_hi [TBL_DEPTH];
   int unsigned ext_cnt;
   logic [31:0] seed_lo, seed_hi;

   extent_answer_type answers_due[$];
   int unsigned send_idle_pct, recv_idle_pct;
   int unsigned mismatches, checked;
   int unsigned op_seen [8];

   block_extent_set_engine_unit #(.MAX_EXTENTS(TBL_DEPTH)) u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[block_extent_set_engine_unit] ERROR");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic int unsigned first_ending_past(logic [31:0] b);
      int unsigned i;
      i = 0;
      while (i < ext_cnt && ext_hi[i] <= b) i++;
      return i;
   endfunction

   function automatic logic [31:0] scan_from(logic [31:0] b, bit want_in);
      int unsigned i;
      logic [31:0] s, e;
      bit hit;
      i = first_ending_past(b);
      if (i < ext_cnt) begin
         s = ext_lo[i];
         e = ext_hi[i];
      end else if (seed_lo < seed_hi && seed_hi > b) begin
         s = seed_lo;
         e = seed_hi;
      end else begin
         s = '0;
         e = '0;
      end
      hit = (s <= b) && (b < e);
      if (hit == want_in) return b;
      return want_in ? s : e;
   endfunction

   function automatic bit range_full(logic [31:0] s, logic [31:0] e);
      return scan_from(s, 1) == s && scan_from(s, 0) >= e;
   endfunction

   function automatic bit range_clear(logic [31:0] s, logic [31:0] e);
      logic [31:0] b;
      b = scan_from(s, 1);
      return b == 0 || b >= e;
   endfunction

   function automatic void drop_extent(int unsigned i);
      for (int unsigned j = i; j + 1 < ext_cnt; j++) begin
         ext_lo[j] = ext_lo[j+1];
         ext_hi[j] = ext_hi[j+1];
      end
      ext_cnt--;
   endfunction

   function automatic void open_extent(int unsigned i, logic [31:0] s, logic [31:0] e);
      for (int unsigned j = ext_cnt; j > i; j--) begin
         ext_lo[j] = ext_lo[j-1];
         ext_hi[j] = ext_hi[j-1];
      end
      ext_lo[i] = s;
      ext_hi[i] = e;
      ext_cnt++;
   endfunction

   function automatic logic [1:0] merge_extent(logic [31:0] s, logic [31:0] e);
      int unsigned i;
      bit lft, rgt;
      if (s >= e || seed_lo < seed_hi || !range_clear(s, e)) return bes_pkg::ST_BAD;
      i = 0;
      while (i < ext_cnt && ext_lo[i] <= s) i++;
      lft = i > 0 && ext_hi[i-1] == s;
      rgt = i < ext_cnt && ext_lo[i] == e;
      if (lft && rgt) begin
         ext_hi[i-1] = ext_hi[i];
         drop_extent(i);
      end else if (lft) begin
         ext_hi[i-1] = e;
      end else if (rgt) begin
         ext_lo[i] = s;
      end else begin
         if (ext_cnt >= TBL_DEPTH) return bes_pkg::ST_FULL;
         open_extent(i, s, e);
      end
      return bes_pkg::ST_OK;
   endfunction

   function automatic logic [1:0] carve_extent(logic [31:0] s, logic [31:0] e);
      int unsigned i;
      logic [31:0] ts, te;
      if (s >= e || seed_lo < seed_hi || !range_full(s, e)) return bes_pkg::ST_BAD;
      i = first_ending_past(s);
      if (i >= ext_cnt) return bes_pkg::ST_BAD;
      ts = ext_lo[i];
      te = ext_hi[i];
      if (s == ts && e == te) begin
         drop_extent(i);
      end else if (s == ts) begin
         ext_lo[i] = e;
      end else if (e == te) begin
         ext_hi[i] = s;
      end else begin
         if (ext_cnt >= TBL_DEPTH) return bes_pkg::ST_FULL;
         open_extent(i + 1, e, te);
         ext_hi[i] = s;
      end
      return bes_pkg::ST_OK;
   endfunction

   function automatic extent_answer_type apply_request(logic [2:0] op, logic [31:0] f,
                                                       logic [31:0] e);
      extent_answer_type a;
      a = '0;
      case (op)
         bes_pkg::OP_ADD: begin
            a.status = merge_extent(f, e);
         end
         bes_pkg::OP_REMOVE: begin
            a.status = carve_extent(f, e);
         end
         bes_pkg::OP_NEXT_RANGE: begin
            a.range_start = scan_from(f, 1);
            a.range_end = (a.range_start != 0) ? scan_from(a.range_start, 0) : '0;
         end
         bes_pkg::OP_NEXT_FREE: begin
            a.next_free = scan_from(f, 0);
         end
         bes_pkg::OP_CHECK: begin
            a.all_in_set = range_full(f, e);
            a.none_in_set = range_clear(f, e);
         end
         default: begin
            a.status = bes_pkg::ST_BAD;
         end
      endcase
      return a;
   endfunction

   // ---------------- bus drivers ----------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_req(logic [2:0] op, logic [31:0] f, logic [31:0] e);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_first_block <= f;
      req_end_block <= e;
      do @(posedge clock); while (!req_ready);
      answers_due.push_back(apply_request(op, f, e));
      op_seen[op]++;
   endtask

   // drop valid and wait until the block has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] s, logic [31:0] e);
      settle();
      csr_valid <= 1'b1;
      csr_index <= bes_pkg::CSR_INIT_START;
      csr_wdata <= s;
      do @(posedge clock); while (!csr_ready);
      seed_lo = s;
      csr_index <= bes_pkg::CSR_INIT_END;
      csr_wdata <= e;
      do @(posedge clock); while (!csr_ready);
      seed_hi = e;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------- response check ----------------
   always @(posedge clock) begin
      extent_answer_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_range_start, rsp_range_end, rsp_next_free,
                 rsp_all_in_set, rsp_none_in_set};
         checked++;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      send_req(bes_pkg::OP_ADD, 32'd10, 32'd20);
      send_req(bes_pkg::OP_ADD, 32'd20, 32'd30);     // grow left neighbor
      send_req(bes_pkg::OP_ADD, 32'd5, 32'd10);      // grow right neighbor
      send_req(bes_pkg::OP_ADD, 32'd40, 32'd50);
      send_req(bes_pkg::OP_ADD, 32'd30, 32'd40);     // bridge both
      send_req(bes_pkg::OP_ADD, 32'd0, 32'd0);       // empty
      send_req(bes_pkg::OP_ADD, 32'd9, 32'd3);       // reversed
      send_req(bes_pkg::OP_ADD, 32'd15, 32'd25);     // overlap
      send_req(bes_pkg::OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send_req(bes_pkg::OP_REMOVE, 32'd5, 32'd8);    // trim front
      send_req(bes_pkg::OP_REMOVE, 32'd45, 32'd50);  // trim back
      send_req(bes_pkg::OP_REMOVE, 32'd20, 32'd25);  // split
      send_req(bes_pkg::OP_REMOVE, 32'd100, 32'd110);
      send_req(bes_pkg::OP_REMOVE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send_req(bes_pkg::OP_NEXT_RANGE, 32'd0, 32'd0);
      send_req(bes_pkg::OP_NEXT_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(bes_pkg::OP_NEXT_FREE, 32'd8, 32'd0);
      send_req(bes_pkg::OP_NEXT_FREE, 32'hFFFF_FFFF, 32'd0);
      send_req(bes_pkg::OP_CHECK, 32'd10, 32'd15);
      send_req(bes_pkg::OP_CHECK, 32'd18, 32'd30);
      send_req(bes_pkg::OP_CHECK, 32'd60, 32'd50);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
         send_req(op[2:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_seed_extent();
      write_seed(32'd100, 32'hFFFF_FFFF);
      send_req(bes_pkg::OP_ADD, 32'd1, 32'd2);
      send_req(bes_pkg::OP_REMOVE, 32'd10, 32'd12);
      send_req(bes_pkg::OP_NEXT_RANGE, 32'd60, 32'd0);
      send_req(bes_pkg::OP_NEXT_FREE, 32'd200, 32'd0);
      send_req(bes_pkg::OP_CHECK, 32'd150, 32'd400);
      write_seed(32'hFFFF_FFFF, 32'd0);
   endtask

   // fill the table to the brim, then try a split and drain it again
   task automatic test_table_full();
      logic [31:0] base;
      base = 32'h1000_0000;
      for (int k = 0; k < TBL_DEPTH + 4; k++)
         send_req(bes_pkg::OP_ADD, base + 5 * k, base + 5 * k + 3);
      send_req(bes_pkg::OP_REMOVE, base + 1, base + 2);
      send_req(bes_pkg::OP_REMOVE, base + 6, base + 7);
      for (int k = 0; k < TBL_DEPTH + 4; k++)
         send_req(bes_pkg::OP_REMOVE, base + 5 * k, base + 5 * k + 3);
   endtask

   task automatic random_request(bit seeded);
      logic [2:0] op;
      logic [31:0] f, e, len, a, b;
      int unsigned pick, i;
      pick = $urandom_range(99);
      f = $urandom_range(400);
      e = f + $urandom_range(24) - 2;
      if (seeded) op = 3'(bes_pkg::OP_NEXT_RANGE + $urandom_range(2));
      else if (pick < 40) op = bes_pkg::OP_ADD;
      else if (pick < 65) op = bes_pkg::OP_REMOVE;
      else op = 3'(bes_pkg::OP_NEXT_RANGE + $urandom_range(2));
      if (op == bes_pkg::OP_REMOVE && ext_cnt > 0 && $urandom_range(3) != 0) begin
         i = $urandom_range(ext_cnt - 1);
         len = ext_hi[i] - ext_lo[i];
         a = $urandom_range(len - 1);
         b = $urandom_range(len, a + 1);
         f = ext_lo[i] + a;
         e = ext_lo[i] + b;
      end
      if ($urandom_range(9) == 0) begin
         op = 3'($urandom);
         f = $urandom;
         e = $urandom;
      end
      send_req(op, f, e);
   endtask

   task automatic test_random(int unsigned s_pct, int unsigned r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (130) random_request(0);
      write_seed($urandom_range(500), $urandom_range(600, 300));
      repeat (20) random_request(1);
      write_seed(32'd0, 32'd0);
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      mismatches = 0;
      checked = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
      ext_cnt = 0;
      seed_lo = '0;
      seed_hi = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 19;
      recv_idle_pct = 61;
      test_directed();
      test_seed_extent();
      test_table_full();
      test_random(19, 61);
      test_random(61, 19);
      test_random(0, 0);
      settle();
      $display("requests add/remove/range/free/check/unused: %0d/%0d/%0d/%0d/%0d/%0d",
               op_seen[bes_pkg::OP_ADD], op_seen[bes_pkg::OP_REMOVE],
               op_seen[bes_pkg::OP_NEXT_RANGE], op_seen[bes_pkg::OP_NEXT_FREE],
               op_seen[bes_pkg::OP_CHECK], op_seen[5] + op_seen[6] + op_seen[7]);
      $display("responses checked: %0d, mismatches: %0d", checked, mismatches);
      if (mismatches == 0 && answers_due.size() == 0)
         $display("[block_extent_set_engine_unit] OK");
      else
         $display("[block_extent_set_engine_unit] ERROR");
      $finish;
   end

endmodule

@@ block_extent_set_engine_unit.f @@
+incdir+design
design/bes_pkg.sv
design/bes_ram.sv
design/bes_ctrl.sv
design/bes_dp.sv
design/block_extent_set_engine_unit.sv
tb/tb_top.sv
